[src/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Request and result structs, operation and status codes, datapath width.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int MW    = 2 * WIDTH;

    localparam logic [2:0] ACT_MAKE = 3'd0;
    localparam logic [2:0] ACT_ADD  = 3'd1;
    localparam logic [2:0] ACT_SUB  = 3'd2;
    localparam logic [2:0] ACT_MUL  = 3'd3;
    localparam logic [2:0] ACT_DIV  = 3'd4;
    localparam logic [2:0] ACT_NEG  = 3'd5;
    localparam logic [2:0] ACT_INV  = 3'd6;
    localparam logic [2:0] ACT_CMP  = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } res_t;

    // control between sequencer and the shared divide/remainder unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

[src/rau_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_divider: shared restoring divider
// One quotient bit per cycle over MW-bit unsigned operands.
// ----------------------------------------------------------------------------
module rau_divider
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [rau_pkg::MW-1:0]   dividend,
    input  logic [rau_pkg::MW-1:0]   divisor,
    output rau_pkg::div_ctl_t        ctl,
    output logic [rau_pkg::MW-1:0]   quotient,
    output logic [rau_pkg::MW-1:0]   remainder
);

    localparam int CW = $clog2(rau_pkg::MW + 1);

    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [rau_pkg::MW-1:0]   q_reg, q_next;
    logic [rau_pkg::MW-1:0]   r_reg, r_next;
    logic [rau_pkg::MW-1:0]   d_reg, d_next;
    logic [rau_pkg::MW:0]     trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[rau_pkg::MW-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(rau_pkg::MW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one bit in, subtract when it fits
            if (!trial[rau_pkg::MW])
            begin
                r_next = trial[rau_pkg::MW-1:0];
                q_next = {q_reg[rau_pkg::MW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[rau_pkg::MW-2:0], q_reg[rau_pkg::MW-1]};
                q_next = {q_reg[rau_pkg::MW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign ctl.start  = start;
    assign ctl.busy   = busy_reg;
    assign ctl.done   = done_reg;
    assign quotient   = q_reg;
    assign remainder  = r_reg;

endmodule

[src/rational_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: reduced rational arithmetic
// Cross-multiplies exactly, reduces by Euclidean GCD, flags errors.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  req      | in        | req_valid/stall   | rau_pkg::req_t
//  res      | out       | res_valid/stall   | rau_pkg::res_t
//
// One request at a time. Products use a shared 32x32 multiplier, one in each
// of the states M1, M2 and M3; each Euclid step and each exact division uses
// the shared 64-bit restoring divider. Compare results go out after COMB, and
// a zero denominator or divisor is flagged at acceptance and goes straight to
// the output. Reset is asynchronous and clears the sequencer.
// A finished result holds in the output register until res_stall drops; the
// next request may be accepted and worked on meanwhile.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  rau_pkg::req_t   req,
    output logic            res_valid,
    input  logic            res_stall,
    output rau_pkg::res_t   res
);

    localparam int W  = rau_pkg::WIDTH;
    localparam int MW = rau_pkg::MW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_M3   = 4'd3;
    localparam logic [3:0] S_COMB = 4'd4;
    localparam logic [3:0] S_GST  = 4'd5;
    localparam logic [3:0] S_GWT  = 4'd6;
    localparam logic [3:0] S_DNS  = 4'd7;
    localparam logic [3:0] S_DNW  = 4'd8;
    localparam logic [3:0] S_DDS  = 4'd9;
    localparam logic [3:0] S_DDW  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]           state_reg, state_next;
    logic [2:0]           act_reg;
    logic signed [W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic [MW-1:0]        p1_reg, p2_reg, p3_reg;
    logic                 s1_reg, s2_reg, s3_reg;
    logic [MW-1:0]        nm_reg, dm_reg, ga_reg, gb_reg;
    logic                 nn_reg, dn_reg;
    logic                 out_valid_reg;
    rau_pkg::res_t        wres_reg;
    rau_pkg::res_t        out_reg;
    logic                 out_load;

    // shared multiplier
    logic [W-1:0]         mx, my;
    logic                 mxs, mys;
    logic [MW-1:0]        mprod;

    logic                 div_start;
    logic [MW-1:0]        div_a, div_b, div_q, div_r;
    rau_pkg::div_ctl_t    dctl;

    rau_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .ctl       (dctl),
        .quotient  (div_q),
        .remainder (div_r)
    );

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        mag = x[W-1] ? W'(-x) : W'(x);
    endfunction

    always_comb
    begin
        mx = mag(an_reg); my = mag(bd_reg); mxs = an_reg[W-1]; mys = bd_reg[W-1];
        unique case (state_reg)
            S_M1:
            begin
                mx = mag(an_reg);
                mxs = an_reg[W-1];
                if (act_reg == rau_pkg::ACT_MUL)
                begin
                    my = mag(bn_reg); mys = bn_reg[W-1];
                end
                else
                begin
                    my = mag(bd_reg); mys = bd_reg[W-1];
                end
            end
            S_M2:
            begin
                mx = mag(bn_reg); my = mag(ad_reg); mxs = bn_reg[W-1]; mys = ad_reg[W-1];
            end
            S_M3:
            begin
                mx = mag(ad_reg); mxs = ad_reg[W-1];
                if (act_reg == rau_pkg::ACT_DIV)
                begin
                    my = mag(bn_reg); mys = bn_reg[W-1];
                end
                else
                begin
                    my = mag(bd_reg); mys = bd_reg[W-1];
                end
            end
            default:
            begin
            end
        endcase
        mprod = MW'(mx) * MW'(my);
    end

    // signed comparison for compare: l vs r from sign-magnitude products
    function automatic logic [1:0] cmp_sm(input logic sa, input logic [MW-1:0] ma,
                                          input logic sb, input logic [MW-1:0] mb);
        logic za, zb, pa, pb;
        za = (ma == '0); zb = (mb == '0);
        pa = sa & !za; pb = sb & !zb;
        if (za && zb)
            cmp_sm = rau_pkg::ORD_EQ;
        else if (pa != pb)
            cmp_sm = pa ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
        else if (ma == mb)
            cmp_sm = rau_pkg::ORD_EQ;
        else if ((ma < mb) != pa)
            cmp_sm = rau_pkg::ORD_LT;
        else
            cmp_sm = rau_pkg::ORD_GT;
    endfunction

    logic                zero_err;
    logic [1:0]          ord_w;
    logic                sgn_w;
    logic [MW-1:0]       sum_w;
    logic                t2_w;
    logic                ovf_w;
    logic [MW-1:0]       lim_w;

    always_comb
    begin
        zero_err = (req.a_den[W-1:0] == '0)
                 || ((req.action == rau_pkg::ACT_ADD || req.action == rau_pkg::ACT_SUB
                      || req.action == rau_pkg::ACT_MUL || req.action == rau_pkg::ACT_DIV
                      || req.action == rau_pkg::ACT_CMP) && req.b_den[W-1:0] == '0)
                 || (req.action == rau_pkg::ACT_DIV && req.b_num[W-1:0] == '0)
                 || (req.action == rau_pkg::ACT_INV && req.a_num[W-1:0] == '0);

        ord_w = cmp_sm(s1_reg, p1_reg, s2_reg, p2_reg);
        if ((ad_reg[W-1] != bd_reg[W-1]) && ord_w != rau_pkg::ORD_EQ)
            ord_w = (ord_w == rau_pkg::ORD_LT) ? rau_pkg::ORD_GT : rau_pkg::ORD_LT;

        t2_w = s2_reg;
        if (act_reg == rau_pkg::ACT_SUB && p2_reg != '0)
            t2_w = !s2_reg;
        if (s1_reg == t2_w)
        begin
            sum_w = p1_reg + p2_reg; sgn_w = s1_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum_w = p1_reg - p2_reg; sgn_w = s1_reg;
        end
        else
        begin
            sum_w = p2_reg - p1_reg; sgn_w = t2_w;
        end

        lim_w = MW'(1) << (W - 1);
        ovf_w = (dm_reg > lim_w - 1'b1)
             || (nm_reg > ((nn_reg != dn_reg) ? lim_w : lim_w - 1'b1));
    end

    always_comb
    begin
        div_start = 1'b0;
        div_a = ga_reg;
        div_b = gb_reg;
        unique case (state_reg)
            S_GST: div_start = 1'b1;
            S_DNS:
            begin
                div_start = 1'b1; div_a = nm_reg; div_b = ga_reg;
            end
            S_DDS:
            begin
                div_start = 1'b1; div_a = dm_reg; div_b = ga_reg;
            end
            default:
            begin
            end
        endcase
    end

    // move the finished result into the output register once it is free
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !res_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (req_valid)
                    state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_COMB;
            S_COMB: state_next = S_GST;
            S_GST:  state_next = S_GWT;
            S_GWT:
                if (dctl.done)
                    state_next = (div_r == '0) ? S_DNS : S_GST;
            S_DNS:  state_next = S_DNW;
            S_DNW:  if (dctl.done) state_next = S_DDS;
            S_DDS:  state_next = S_DDW;
            S_DDW:  if (dctl.done) state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE && req_valid && zero_err)
            state_next = S_OUT;
        if (state_reg == S_COMB && (act_reg == rau_pkg::ACT_CMP))
            state_next = S_OUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !res_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (req_valid)
                begin
                    act_reg <= req.action;
                    an_reg <= req.a_num[W-1:0];
                    ad_reg <= req.a_den[W-1:0];
                    bn_reg <= req.b_num[W-1:0];
                    bd_reg <= req.b_den[W-1:0];
                    wres_reg <= '{res_num: '0, res_den: '0, order: rau_pkg::ORD_LT,
                                  status: zero_err ? rau_pkg::ST_ZERO : rau_pkg::ST_OK};
                end
            S_M1:
            begin
                p1_reg <= mprod; s1_reg <= mxs ^ mys;
            end
            S_M2:
            begin
                p2_reg <= mprod; s2_reg <= mxs ^ mys;
            end
            S_M3:
            begin
                p3_reg <= mprod; s3_reg <= mxs ^ mys;
            end
            S_COMB:
            begin
                // pick numerator and denominator magnitudes and signs
                case (act_reg) inside
                    rau_pkg::ACT_ADD, rau_pkg::ACT_SUB:
                    begin
                        nm_reg <= sum_w; nn_reg <= sgn_w;
                        dm_reg <= p3_reg; dn_reg <= s3_reg;
                    end
                    rau_pkg::ACT_MUL, rau_pkg::ACT_DIV:
                    begin
                        nm_reg <= p1_reg; nn_reg <= s1_reg;
                        dm_reg <= p3_reg; dn_reg <= s3_reg;
                    end
                    rau_pkg::ACT_INV:
                    begin
                        nm_reg <= MW'(mag(ad_reg)); nn_reg <= ad_reg[W-1];
                        dm_reg <= MW'(mag(an_reg)); dn_reg <= an_reg[W-1];
                    end
                    default:
                    begin
                        nm_reg <= MW'(mag(an_reg));
                        nn_reg <= (act_reg == rau_pkg::ACT_NEG) ? !an_reg[W-1] : an_reg[W-1];
                        dm_reg <= MW'(mag(ad_reg)); dn_reg <= ad_reg[W-1];
                    end
                endcase
                if (act_reg == rau_pkg::ACT_CMP)
                    wres_reg.order <= ord_w;
                case (act_reg) inside
                    rau_pkg::ACT_ADD, rau_pkg::ACT_SUB:
                    begin
                        ga_reg <= sum_w; gb_reg <= p3_reg;
                    end
                    rau_pkg::ACT_MUL, rau_pkg::ACT_DIV:
                    begin
                        ga_reg <= p1_reg; gb_reg <= p3_reg;
                    end
                    rau_pkg::ACT_INV:
                    begin
                        ga_reg <= MW'(mag(ad_reg)); gb_reg <= MW'(mag(an_reg));
                    end
                    default:
                    begin
                        ga_reg <= MW'(mag(an_reg)); gb_reg <= MW'(mag(ad_reg));
                    end
                endcase
            end
            S_GWT:
                if (dctl.done)
                begin
                    // advance Euclid: (a, b) <- (b, a mod b); zero numerator gives g = den
                    ga_reg <= gb_reg;
                    gb_reg <= div_r;
                end
            S_DNW:
                if (dctl.done)
                    nm_reg <= div_q;
            S_DDW:
                if (dctl.done)
                    dm_reg <= div_q;
            S_FIN:
            begin
                if (nm_reg == '0)
                begin
                    wres_reg.res_num <= '0; wres_reg.res_den <= 31'd1;
                end
                else if (ovf_w)
                begin
                    wres_reg.res_num <= '0; wres_reg.res_den <= '0;
                    wres_reg.status <= rau_pkg::ST_OVF;
                end
                else
                begin
                    wres_reg.res_num <= (nn_reg != dn_reg) ? 32'(-$signed({1'b0, nm_reg}))
                                                           : 32'(nm_reg);
                    wres_reg.res_den <= 31'(dm_reg);
                end
            end
            S_OUT:
                if (out_load)
                    out_reg <= wres_reg;
            default:
            begin
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n) (state_reg != S_IDLE) |-> req_stall;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_out_after_seq;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_OUT) |=> res_valid;
    endproperty
    a_out_after_seq: assert property (p_out_after_seq) else $error("result lost");

    property p_div_idle;
        @(posedge clk) disable iff (!rst_n) dctl.busy |-> (state_reg == S_GWT
            || state_reg == S_DNW || state_reg == S_DDW);
    endproperty
    a_div_idle: assert property (p_div_idle) else $error("divider busy out of sequence");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for rational_arithmetic_unit_core
// Drives directed and random fraction requests through a valid/stall channel,
// predicts each reduced result and checks the result channel field by field,
// with the sender idling and the receiver stalling in several phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 8000;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    rau_pkg::req_t  req;
    logic           res_valid;
    logic           res_stall;
    rau_pkg::res_t  res;

    rau_pkg::req_t  pending_reqs[$];
    rau_pkg::res_t  expected_results[$];
    int    send_idle_pct;
    int    recv_stall_pct;
    int    error_count;
    int    quiet_cycles;

    rational_arithmetic_unit_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint unsigned mag64(logic signed [63:0] x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Exact rational result of one request, reduced, denominator positive.
    function automatic rau_pkg::res_t reduce_rational(rau_pkg::req_t r);
        logic signed [63:0] an, ad, bn, bd, lhs, rhs;
        bit nn, dn, t1, t2;
        longint unsigned nm, dm, m1, m2, g, lim;
        logic [1:0] o;
        rau_pkg::res_t p;
        p = '0;
        an = r.a_num;
        ad = r.a_den;
        bn = r.b_num;
        bd = r.b_den;
        nn = 0;
        dn = 0;
        nm = 0;
        dm = 0;
        if (ad == 0 || (r.action inside {rau_pkg::ACT_ADD, rau_pkg::ACT_SUB, rau_pkg::ACT_MUL,
                                         rau_pkg::ACT_DIV, rau_pkg::ACT_CMP}
                && bd == 0) || (r.action == rau_pkg::ACT_DIV && bn == 0)
                || (r.action == rau_pkg::ACT_INV && an == 0))
        begin
            p.status = rau_pkg::ST_ZERO;
            return p;
        end
        case (r.action) inside
            rau_pkg::ACT_MAKE, rau_pkg::ACT_NEG:
            begin
                nn = (an < 0) ^ (r.action == rau_pkg::ACT_NEG);
                nm = mag64(an);
                dn = ad < 0;
                dm = mag64(ad);
            end
            rau_pkg::ACT_ADD, rau_pkg::ACT_SUB:
            begin
                m1 = mag64(an) * mag64(bd);
                t1 = (an < 0) != (bd < 0);
                m2 = mag64(bn) * mag64(ad);
                t2 = (bn < 0) != (ad < 0);
                if (r.action == rau_pkg::ACT_SUB && m2 != 0)
                    t2 = !t2;
                if (t1 == t2)
                begin
                    nn = t1;
                    nm = m1 + m2;
                end
                else if (m1 >= m2)
                begin
                    nn = t1;
                    nm = m1 - m2;
                end
                else
                begin
                    nn = t2;
                    nm = m2 - m1;
                end
                dm = mag64(ad) * mag64(bd);
                dn = (ad < 0) != (bd < 0);
            end
            rau_pkg::ACT_MUL:
            begin
                nm = mag64(an) * mag64(bn);
                nn = (an < 0) != (bn < 0);
                dm = mag64(ad) * mag64(bd);
                dn = (ad < 0) != (bd < 0);
            end
            rau_pkg::ACT_DIV:
            begin
                nm = mag64(an) * mag64(bd);
                nn = (an < 0) != (bd < 0);
                dm = mag64(ad) * mag64(bn);
                dn = (ad < 0) != (bn < 0);
            end
            rau_pkg::ACT_INV:
            begin
                nn = ad < 0;
                nm = mag64(ad);
                dn = an < 0;
                dm = mag64(an);
            end
            default:
            begin
                lhs = an * bd;
                rhs = bn * ad;
                o = (lhs < rhs) ? rau_pkg::ORD_LT
                                : ((lhs == rhs) ? rau_pkg::ORD_EQ : rau_pkg::ORD_GT);
                // flip the order when exactly one denominator is negative
                if (((ad < 0) != (bd < 0)) && o != rau_pkg::ORD_EQ)
                    o = (o == rau_pkg::ORD_LT) ? rau_pkg::ORD_GT : rau_pkg::ORD_LT;
                p.order = o;
                return p;
            end
        endcase
        if (nm == 0)
        begin
            p.res_den = 31'd1;
            return p;
        end
        g = euclid_gcd(nm, dm);
        nm = nm / g;
        dm = dm / g;
        nn = nn != dn;
        lim = 64'd1 << (rau_pkg::WIDTH - 1);
        if (dm > lim - 1 || nm > (nn ? lim : lim - 1))
        begin
            p.status = rau_pkg::ST_OVF;
            return p;
        end
        p.res_num = nn ? -nm[31:0] : nm[31:0];
        p.res_den = dm[30:0];
        return p;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 4))
            0: return 32'($signed($urandom_range(0, 40)) - 20);
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return {{16{1'b0}}, 16'($urandom)} ^ ({32{$urandom_range(0, 1) == 1}});
            3: return $urandom;
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0001;
                    4: return 32'h0000_0000;
                    default: return 32'h8000_0001;
                endcase
            end
        endcase
    endfunction

    function automatic rau_pkg::req_t random_request();
        rau_pkg::req_t r;
        r.action = 3'($urandom_range(0, 7));
        r.a_num  = pick_operand();
        r.a_den  = pick_operand();
        r.b_num  = pick_operand();
        r.b_den  = pick_operand();
        // keep most denominators nonzero so the arithmetic path is exercised
        if (r.a_den == 0 && $urandom_range(0, 3) != 0)
            r.a_den = 32'd7;
        if (r.b_den == 0 && $urandom_range(0, 3) != 0)
            r.b_den = -32'sd3;
        return r;
    endfunction

    function automatic rau_pkg::req_t make_req(logic [2:0] act, logic [31:0] an,
                                               logic [31:0] ad, logic [31:0] bn,
                                               logic [31:0] bd);
        rau_pkg::req_t r;
        r.action = act;
        r.a_num  = an;
        r.a_den  = ad;
        r.b_num  = bn;
        r.b_den  = bd;
        return r;
    endfunction

    // Driver: advance to the next request once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        rau_pkg::res_t want;
        if (!rst_n)
        begin
            res_stall    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (req_valid && !req_stall)
                expected_results.push_back(reduce_rational(req));
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, res);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.res_num !== res.res_num || want.res_den !== res.res_den
                            || want.order !== res.order || want.status !== res.status)
                    begin
                        $display("%0t: mismatch expected num=%0d den=%0d ord=%0d st=%0d",
                                 $time, want.res_num, want.res_den, want.order, want.status);
                        $display("%0t:          actual   num=%0d den=%0d ord=%0d st=%0d",
                                 $time, res.res_num, res.res_den, res.order, res.status);
                        error_count <= error_count + 1;
                    end
                end
            end
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        rst_n          = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        pending_reqs.push_back(make_req(rau_pkg::ACT_MAKE, 6, -4, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_MAKE, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_MAKE, 32'h8000_0000, 1, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_MAKE, 5, 0, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_MAKE, 0, -9, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_ADD, 1, 2, 1, 3));
        pending_reqs.push_back(make_req(rau_pkg::ACT_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_ADD, 1, 2, 1, 0));
        pending_reqs.push_back(make_req(rau_pkg::ACT_SUB, 1, 3, 1, 3));
        pending_reqs.push_back(make_req(rau_pkg::ACT_SUB, 32'h8000_0000, 1, 1, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_MUL, 2, 3, -3, 4));
        pending_reqs.push_back(make_req(rau_pkg::ACT_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_MUL, 1, 32'h7FFF_FFFF, 1, 2));
        pending_reqs.push_back(make_req(rau_pkg::ACT_DIV, 3, 4, 0, 5));
        pending_reqs.push_back(make_req(rau_pkg::ACT_DIV, 3, 4, -9, 8));
        pending_reqs.push_back(make_req(rau_pkg::ACT_NEG, 32'h8000_0000, 1, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_NEG, 4, -6, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_INV, 0, 5, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_INV, -4, 6, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_INV, 32'h8000_0000, 1, 0, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_CMP, 1, 2, 2, 4));
        pending_reqs.push_back(make_req(rau_pkg::ACT_CMP, 1, -2, 1, 3));
        pending_reqs.push_back(make_req(rau_pkg::ACT_CMP, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1));
        pending_reqs.push_back(make_req(rau_pkg::ACT_CMP, 1, 2, 1, 0));
        pending_reqs.push_back(make_req(rau_pkg::ACT_DIV, 12, 18, 20, 30));

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                3: begin send_idle_pct = 26; recv_stall_pct = 26; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (165) pending_reqs.push_back(random_request());
            while (pending_reqs.size() > 0 || expected_results.size() > 0 || req_valid)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
src/rau_pkg.sv
src/rau_divider.sv
src/rational_arithmetic_unit_core.sv
tb/tb.sv
